@@ design/tspl_pkg.sv @@
// Shared types and constants for the tiled sprite pixel lookup block.
package tspl_pkg;

   localparam int COORD_W  = 16;
   localparam int SIZE_W   = 12;
   localparam int DIM_W    = 5;
   localparam int TEX_W    = 4;
   localparam int COLOUR_W = 4;
   localparam int IDX_W    = 3;
   localparam int REQ_W    = 2;
   localparam int ACT_W    = 4;
   localparam int Q_DEPTH  = 2;
   localparam int Q_PTR_W  = 1;
   localparam int Q_CNT_W  = 2;

   localparam logic [REQ_W-1:0] REQ_DESC  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_TEXEL = 2'd1;
   localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

   typedef enum logic [1:0] {
      OP_DESC,
      OP_TEXEL,
      OP_QUERY
   } op_type;

   typedef struct packed {
      op_type                      op;
      logic [IDX_W-1:0]            idx;
      logic signed [COORD_W-1:0]   x;
      logic signed [COORD_W-1:0]   y;
      logic [SIZE_W-1:0]           w;
      logic [SIZE_W-1:0]           h;
      logic [DIM_W-1:0]            sw;
      logic [DIM_W-1:0]            sh;
      logic [TEX_W-1:0]            row;
      logic [TEX_W-1:0]            col;
      logic [COLOUR_W-1:0]         colour;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_READ,
      BK_CHECK,
      BK_MOD,
      BK_FETCH,
      BK_EMIT
   } back_state_type;

endpackage

@@ design/tspl_ifs.sv @@
// Request and response channel interfaces.
interface tspl_req_if;
   logic                                    valid;
   logic                                    ready;
   logic [tspl_pkg::REQ_W-1:0]              req_type;
   logic [tspl_pkg::IDX_W-1:0]              obj_index;
   logic signed [tspl_pkg::COORD_W-1:0]     coord_x;
   logic signed [tspl_pkg::COORD_W-1:0]     coord_y;
   logic [tspl_pkg::SIZE_W-1:0]             size_w;
   logic [tspl_pkg::SIZE_W-1:0]             size_h;
   logic [tspl_pkg::DIM_W-1:0]              sprite_w;
   logic [tspl_pkg::DIM_W-1:0]              sprite_h;
   logic [tspl_pkg::TEX_W-1:0]              texel_row;
   logic [tspl_pkg::TEX_W-1:0]              texel_col;
   logic [tspl_pkg::COLOUR_W-1:0]           texel_colour;

   modport source (
      output valid, req_type, obj_index, coord_x, coord_y, size_w, size_h,
             sprite_w, sprite_h, texel_row, texel_col, texel_colour,
      input  ready
   );
   modport sink (
      input  valid, req_type, obj_index, coord_x, coord_y, size_w, size_h,
             sprite_w, sprite_h, texel_row, texel_col, texel_colour,
      output ready
   );
endinterface

interface tspl_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic                                    hit;
   logic [tspl_pkg::COLOUR_W-1:0]           colour;

   modport source (
      output valid, hit, colour,
      input  ready
   );
   modport sink (
      input  valid, hit, colour,
      output ready
   );
endinterface

@@ design/tspl_front.sv @@
// Front end: accept requests, classify and filter them, queue them for the back end.
module tspl_front #(
   parameter int MAX_OBJECTS    = 8,
   parameter int SPRITE_MAX_DIM = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   tspl_req_if.sink                          req,
   output tspl_pkg::head_type                head,
   input  logic                              head_pop,
   output logic [tspl_pkg::Q_CNT_W-1:0]      fill
);

   tspl_pkg::item_type                  q_ff [tspl_pkg::Q_DEPTH];
   logic [tspl_pkg::Q_PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [tspl_pkg::Q_PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [tspl_pkg::Q_CNT_W-1:0]        count_ff, count_in;
   tspl_pkg::item_type                  cls;
   logic                                keep;
   logic                                push;
   logic                                idx_ok;

   assign req.ready = (count_ff != tspl_pkg::Q_CNT_W'(tspl_pkg::Q_DEPTH));
   assign idx_ok    = (32'(req.obj_index) < MAX_OBJECTS);

   always_comb begin
      cls.idx    = req.obj_index;
      cls.x      = req.coord_x;
      cls.y      = req.coord_y;
      cls.w      = req.size_w;
      cls.h      = req.size_h;
      cls.row    = req.texel_row;
      cls.col    = req.texel_col;
      cls.colour = req.texel_colour;
      // clamp sprite dimensions into 1..SPRITE_MAX_DIM
      if (req.sprite_w == '0) begin
         cls.sw = tspl_pkg::DIM_W'(1);
      end else if (32'(req.sprite_w) > SPRITE_MAX_DIM) begin
         cls.sw = tspl_pkg::DIM_W'(SPRITE_MAX_DIM);
      end else begin
         cls.sw = req.sprite_w;
      end
      if (req.sprite_h == '0) begin
         cls.sh = tspl_pkg::DIM_W'(1);
      end else if (32'(req.sprite_h) > SPRITE_MAX_DIM) begin
         cls.sh = tspl_pkg::DIM_W'(SPRITE_MAX_DIM);
      end else begin
         cls.sh = req.sprite_h;
      end
      case (req.req_type)
         tspl_pkg::REQ_DESC: begin
            cls.op = tspl_pkg::OP_DESC;
            keep   = idx_ok;
         end
         tspl_pkg::REQ_TEXEL: begin
            cls.op = tspl_pkg::OP_TEXEL;
            keep   = idx_ok && (32'(req.texel_row) < SPRITE_MAX_DIM)
                     && (32'(req.texel_col) < SPRITE_MAX_DIM);
         end
         tspl_pkg::REQ_QUERY: begin
            cls.op = tspl_pkg::OP_QUERY;
            keep   = 1'b1;
         end
         default: begin
            cls.op = tspl_pkg::OP_QUERY;
            keep   = 1'b0;
         end
      endcase
   end

   assign push = req.valid && req.ready && keep;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = head_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !head_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && head_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = q_ff[rd_ptr_ff];
   assign fill       = count_ff;

endmodule

@@ design/tspl_mod.sv @@
// Two-lane bit-serial remainder unit for the sprite tiling offsets.
module tspl_mod (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [tspl_pkg::COORD_W-1:0]      num_x,
   input  logic [tspl_pkg::COORD_W-1:0]      num_y,
   input  logic [tspl_pkg::DIM_W-1:0]        den_x,
   input  logic [tspl_pkg::DIM_W-1:0]        den_y,
   output logic                              done,
   output logic [tspl_pkg::DIM_W-1:0]        rem_x,
   output logic [tspl_pkg::DIM_W-1:0]        rem_y
);

   localparam int CNT_W = $clog2(tspl_pkg::COORD_W);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(tspl_pkg::COORD_W - 1);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [CNT_W-1:0]                  cnt_ff, cnt_in;
   logic [tspl_pkg::COORD_W-1:0]      sx_ff, sx_in, sy_ff, sy_in;
   logic [tspl_pkg::DIM_W-1:0]        rx_ff, rx_in, ry_ff, ry_in;
   logic [tspl_pkg::DIM_W-1:0]        dx_ff, dx_in, dy_ff, dy_in;
   logic [tspl_pkg::DIM_W:0]          tx, ty;

   always_comb begin
      tx      = {rx_ff, sx_ff[tspl_pkg::COORD_W-1]};
      ty      = {ry_ff, sy_ff[tspl_pkg::COORD_W-1]};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      sx_in   = sx_ff;
      sy_in   = sy_ff;
      rx_in   = rx_ff;
      ry_in   = ry_ff;
      dx_in   = dx_ff;
      dy_in   = dy_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         sx_in   = num_x;
         sy_in   = num_y;
         rx_in   = '0;
         ry_in   = '0;
         dx_in   = den_x;
         dy_in   = den_y;
      end else if (busy_ff) begin
         sx_in  = {sx_ff[tspl_pkg::COORD_W-2:0], 1'b0};
         sy_in  = {sy_ff[tspl_pkg::COORD_W-2:0], 1'b0};
         rx_in  = (tx >= {1'b0, dx_ff}) ? tspl_pkg::DIM_W'(tx - {1'b0, dx_ff})
                                        : tx[tspl_pkg::DIM_W-1:0];
         ry_in  = (ty >= {1'b0, dy_ff}) ? tspl_pkg::DIM_W'(ty - {1'b0, dy_ff})
                                        : ty[tspl_pkg::DIM_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sx_ff <= sx_in;
      sy_ff <= sy_in;
      rx_ff <= rx_in;
      ry_ff <= ry_in;
      dx_ff <= dx_in;
      dy_ff <= dy_in;
   end

   assign done  = done_ff;
   assign rem_x = rx_ff;
   assign rem_y = ry_ff;

endmodule

@@ design/tspl_back.sv @@
// Back end: object and texel stores, query scan sequencer and response register.
module tspl_back #(
   parameter int MAX_OBJECTS    = 8,
   parameter int SPRITE_MAX_DIM = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tspl_pkg::head_type                head,
   output logic                              head_pop,
   input  logic [tspl_pkg::ACT_W-1:0]        active_objects,
   tspl_rsp_if.source                        rsp
);

   localparam int OW        = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
   localparam int CW        = $clog2(MAX_OBJECTS + 1);
   localparam int TEX_DEPTH = MAX_OBJECTS * SPRITE_MAX_DIM * SPRITE_MAX_DIM;
   localparam int TA_W      = (TEX_DEPTH > 1) ? $clog2(TEX_DEPTH) : 1;
   localparam int CO        = tspl_pkg::COORD_W;
   localparam int EW        = tspl_pkg::COORD_W + 2;

   logic [2*CO-1:0]                        origin_mem [MAX_OBJECTS];
   logic [2*tspl_pkg::SIZE_W-1:0]          extent_mem [MAX_OBJECTS];
   logic [2*tspl_pkg::DIM_W-1:0]           dims_mem   [MAX_OBJECTS];
   logic [tspl_pkg::COLOUR_W-1:0]          tex_mem    [TEX_DEPTH];

   logic [2*CO-1:0]                        origin_rd_ff;
   logic [2*tspl_pkg::SIZE_W-1:0]          extent_rd_ff;
   logic [2*tspl_pkg::DIM_W-1:0]           dims_rd_ff;
   logic [tspl_pkg::COLOUR_W-1:0]          tex_rd_ff;

   tspl_pkg::back_state_type               state_ff, state_in;
   logic [CW-1:0]                          scan_ff, scan_in;
   logic [CW-1:0]                          n_ff, n_in, n_req;
   logic                                   hit_flag_ff, hit_flag_in;
   logic signed [CO-1:0]                   px_ff, px_in, py_ff, py_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic                                   rsp_hit_ff, rsp_hit_in;
   logic [tspl_pkg::COLOUR_W-1:0]          rsp_colour_ff, rsp_colour_in;

   logic                                   obj_wr, tex_wr, obj_rd, tex_rd;
   logic                                   mod_start, mod_done;
   logic [tspl_pkg::DIM_W-1:0]             rem_x, rem_y;
   logic signed [CO-1:0]                   ox, oy;
   logic [tspl_pkg::SIZE_W-1:0]            ow, oh;
   logic [tspl_pkg::DIM_W-1:0]             sw, sh;
   logic signed [EW-1:0]                   ex, ey, px_e, py_e;
   logic                                   in_box;
   logic [CO-1:0]                          dx, dy;
   logic [TA_W-1:0]                        tex_wr_addr, tex_rd_addr;

   assign n_req = (32'(active_objects) > MAX_OBJECTS) ? CW'(MAX_OBJECTS)
                                                      : CW'(active_objects);

   always_comb begin
      ox   = origin_rd_ff[CO-1:0];
      oy   = origin_rd_ff[2*CO-1:CO];
      ow   = extent_rd_ff[tspl_pkg::SIZE_W-1:0];
      oh   = extent_rd_ff[2*tspl_pkg::SIZE_W-1:tspl_pkg::SIZE_W];
      sw   = dims_rd_ff[tspl_pkg::DIM_W-1:0];
      sh   = dims_rd_ff[2*tspl_pkg::DIM_W-1:tspl_pkg::DIM_W];
      px_e = {{2{px_ff[CO-1]}}, px_ff};
      py_e = {{2{py_ff[CO-1]}}, py_ff};
      if ((ow == '0) || (oh == '0)) begin
         ex = '0;
         ey = '0;
      end else begin
         ex = $signed({{2{ox[CO-1]}}, ox} + {{(EW-tspl_pkg::SIZE_W){1'b0}}, ow}
                      - EW'(1));
         ey = $signed({{2{oy[CO-1]}}, oy} + {{(EW-tspl_pkg::SIZE_W){1'b0}}, oh}
                      - EW'(1));
      end
      in_box = (ox <= px_ff) && (px_e <= ex) && (oy <= py_ff) && (py_e <= ey);
      dx     = px_ff - ox;
      dy     = py_ff - oy;
      if (sw == '0) begin
         sw = tspl_pkg::DIM_W'(1);
      end
      if (sh == '0) begin
         sh = tspl_pkg::DIM_W'(1);
      end
   end

   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      n_in          = n_ff;
      hit_flag_in   = hit_flag_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_hit_in    = rsp_hit_ff;
      rsp_colour_in = rsp_colour_ff;
      head_pop      = 1'b0;
      obj_wr        = 1'b0;
      tex_wr        = 1'b0;
      obj_rd        = 1'b0;
      tex_rd        = 1'b0;
      mod_start     = 1'b0;
      case (state_ff)
         tspl_pkg::BK_IDLE: begin
            if (head.valid) begin
               head_pop = 1'b1;
               case (head.item.op)
                  tspl_pkg::OP_DESC: begin
                     obj_wr = 1'b1;
                  end
                  tspl_pkg::OP_TEXEL: begin
                     tex_wr = 1'b1;
                  end
                  tspl_pkg::OP_QUERY: begin
                     px_in       = head.item.x;
                     py_in       = head.item.y;
                     n_in        = n_req;
                     scan_in     = '0;
                     hit_flag_in = 1'b0;
                     state_in    = (n_req == '0) ? tspl_pkg::BK_EMIT : tspl_pkg::BK_READ;
                  end
                  default: begin
                     state_in = tspl_pkg::BK_IDLE;
                  end
               endcase
            end
         end
         tspl_pkg::BK_READ: begin
            obj_rd   = 1'b1;
            state_in = tspl_pkg::BK_CHECK;
         end
         tspl_pkg::BK_CHECK: begin
            if (in_box) begin
               mod_start   = 1'b1;
               hit_flag_in = 1'b1;
               state_in    = tspl_pkg::BK_MOD;
            end else if (scan_ff + 1'b1 == n_ff) begin
               state_in = tspl_pkg::BK_EMIT;
            end else begin
               scan_in  = scan_ff + 1'b1;
               state_in = tspl_pkg::BK_READ;
            end
         end
         tspl_pkg::BK_MOD: begin
            if (mod_done) begin
               state_in = tspl_pkg::BK_FETCH;
            end
         end
         tspl_pkg::BK_FETCH: begin
            tex_rd   = 1'b1;
            state_in = tspl_pkg::BK_EMIT;
         end
         tspl_pkg::BK_EMIT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_hit_in    = hit_flag_ff;
               rsp_colour_in = hit_flag_ff ? tex_rd_ff : '0;
               state_in      = tspl_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = tspl_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tspl_pkg::BK_IDLE;
         scan_ff      <= '0;
         n_ff         <= '0;
         hit_flag_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         n_ff         <= n_in;
         hit_flag_ff  <= hit_flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff         <= px_in;
      py_ff         <= py_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_colour_ff <= rsp_colour_in;
   end

   always_ff @(posedge clock) begin
      if (obj_wr) begin
         origin_mem[OW'(head.item.idx)] <= {head.item.y, head.item.x};
         extent_mem[OW'(head.item.idx)] <= {head.item.h, head.item.w};
         dims_mem[OW'(head.item.idx)]   <= {head.item.sh, head.item.sw};
      end
      if (obj_rd) begin
         origin_rd_ff <= origin_mem[scan_ff[OW-1:0]];
         extent_rd_ff <= extent_mem[scan_ff[OW-1:0]];
         dims_rd_ff   <= dims_mem[scan_ff[OW-1:0]];
      end
   end

   assign tex_wr_addr = TA_W'(32'(head.item.idx) * SPRITE_MAX_DIM * SPRITE_MAX_DIM
                              + 32'(head.item.row) * SPRITE_MAX_DIM
                              + 32'(head.item.col));
   assign tex_rd_addr = TA_W'(32'(scan_ff) * SPRITE_MAX_DIM * SPRITE_MAX_DIM
                              + 32'(rem_y) * SPRITE_MAX_DIM
                              + 32'(rem_x));

   always_ff @(posedge clock) begin
      if (tex_wr) begin
         tex_mem[tex_wr_addr] <= head.item.colour;
      end
      if (tex_rd) begin
         tex_rd_ff <= tex_mem[tex_rd_addr];
      end
   end

   tspl_mod u_mod (
      .clock (clock),
      .reset (reset),
      .start (mod_start),
      .num_x (dx),
      .num_y (dy),
      .den_x (sw),
      .den_y (sh),
      .done  (mod_done),
      .rem_x (rem_x),
      .rem_y (rem_y)
   );

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.hit    = rsp_hit_ff;
   assign rsp.colour = rsp_colour_ff;

endmodule

@@ design/tiled_sprite_pixel_lookup_core.sv @@
// Tiled sprite pixel lookup top level: config register, front queue, back end.
// A descriptor or texel write goes into its store as it is dequeued. A query is dequeued, then
// each active entry is read and checked in turn; the first entry whose box holds the point starts
// the bit-serial remainder, then the texel read and the response load. A miss loads after the scan.
// The back end takes one item at a time; a waiting response stalls the next query.
// Reset empties the queue, idles the back end and clears active_objects.
module tiled_sprite_pixel_lookup_core #(
   parameter int MAX_OBJECTS    = 8,
   parameter int SPRITE_MAX_DIM = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   tspl_req_if.sink                           req_chan,
   tspl_rsp_if.source                         rsp_chan,
   input  logic                               csr_we,
   input  logic [tspl_pkg::ACT_W-1:0]         csr_wdata
);

   logic [tspl_pkg::ACT_W-1:0]    active_ff;
   tspl_pkg::head_type            head;
   logic                          head_pop;
   logic [tspl_pkg::Q_CNT_W-1:0]  fill;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else if (csr_we) begin
         active_ff <= csr_wdata;
      end
   end

   tspl_front #(
      .MAX_OBJECTS    (MAX_OBJECTS),
      .SPRITE_MAX_DIM (SPRITE_MAX_DIM)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .head     (head),
      .head_pop (head_pop),
      .fill     (fill)
   );

   tspl_back #(
      .MAX_OBJECTS    (MAX_OBJECTS),
      .SPRITE_MAX_DIM (SPRITE_MAX_DIM)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .head_pop       (head_pop),
      .active_objects (active_ff),
      .rsp            (rsp_chan)
   );

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill <= tspl_pkg::Q_CNT_W'(tspl_pkg::Q_DEPTH))
      else $error("request queue overfilled");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head.valid)
      else $error("pop from empty request queue");

   a_miss_colour: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.hit |-> rsp_chan.colour == '0)
      else $error("miss with nonzero colour");

   a_reset_quiet: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_chan.valid)
      else $error("response valid right after reset");

endmodule
